// File: rtl/sbfr_pkg.sv
// Package for the SBUS frame receiver: shared constants, status codes and
// the frame descriptor type that goes from the front end to the back end.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package sbfr_pkg;

    // Field widths of the byte and result transactions.
    localparam int BYTE_W   = 8;
    localparam int CH_W     = 11;
    localparam int IDX_W    = 4;
    localparam int STAT_W   = 2;
    localparam int POS_W    = 5;

    // Frame layout: start byte, 22 payload bytes, status byte, end byte.
    localparam int PAYLOAD_BYTES = 22;
    localparam int PAYLOAD_BITS  = PAYLOAD_BYTES * BYTE_W;
    localparam int OFF_W         = $clog2(PAYLOAD_BITS);
    localparam int STATUS_POS    = 23;
    localparam int END_POS       = 24;

    localparam logic [BYTE_W-1:0] START_BYTE = 8'h0F;
    localparam logic [BYTE_W-1:0] END_BYTE   = 8'h00;

    // Status byte flags; only these two bits may be set in a good frame.
    localparam int LOST_BIT     = 2;
    localparam int FAILSAFE_BIT = 3;
    localparam logic [BYTE_W-1:0] STATUS_FLAG_MASK =
        BYTE_W'((1 << LOST_BIT) | (1 << FAILSAFE_BIT));

    // Channel count bounds.
    localparam int CHANNELS_DEFAULT = 16;
    localparam int CHANNELS_MIN     = 8;
    localparam int CHANNELS_MAX     = 16;

    // Depth of the descriptor queue between front and back end.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input action codes.
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_IDLE = 1'b1;

    // Signal status codes reported with each channel.
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_LOST     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FAILSAFE = 2'd2;

    // One completed frame, as the back end needs it.
    typedef struct packed {
        logic [PAYLOAD_BITS-1:0] payload;   // bytes 1..22, byte 1 in the low bits
        logic [STAT_W-1:0]       status;
        logic                    error;
        logic [IDX_W-1:0]        last_idx;
    } sbfr_frame_t;

endpackage

`default_nettype wire

// File: rtl/sbfr_if.sv
// Handshake interfaces of the SBUS frame receiver: the byte input channel
// and the decoded result channel. Depends on sbfr_pkg for field widths.
`default_nettype none

interface sbfr_in_if;
    import sbfr_pkg::*;

    logic              valid;
    logic              ready;
    logic              action;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface sbfr_out_if;
    import sbfr_pkg::*;

    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  channel_index;
    logic [CH_W-1:0]   channel_value;
    logic [STAT_W-1:0] signal_status;
    logic              frame_error;
    logic              last;

    modport source (output valid, output channel_index, output channel_value,
                    output signal_status, output frame_error, output last,
                    input ready);
    modport sink   (input valid, input channel_index, input channel_value,
                    input signal_status, input frame_error, input last,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/sbfr_front.sv
// Front end of the SBUS frame receiver: hunts for the start byte, collects
// the frame and pushes one descriptor per completed frame.
// Depends on sbfr_pkg and sbfr_in_if.
`default_nettype none

module sbfr_front #(
    parameter int CHANNELS_PER_FRAME = sbfr_pkg::CHANNELS_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    sbfr_in_if.sink                  rx_in,
    input  wire logic                cfg_we,
    input  wire logic                cfg_wdata,
    output      logic                q_push,
    output      sbfr_pkg::sbfr_frame_t q_data,
    input  wire logic                q_ready
);
    import sbfr_pkg::*;

    // The channel count is held to the supported range.
    localparam int CH_COUNT = (CHANNELS_PER_FRAME > CHANNELS_MAX) ? CHANNELS_MAX
                            : (CHANNELS_PER_FRAME < CHANNELS_MIN) ? CHANNELS_MIN
                            : CHANNELS_PER_FRAME;

    logic                    collecting_reg, collecting_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [PAYLOAD_BITS-1:0] payload_reg, payload_next;
    logic [BYTE_W-1:0]       status_reg, status_next;
    logic                    decode_all_reg;
    logic                    accept;
    logic                    at_end;
    logic [POS_W-1:0]        pos_inc;

    // The end byte needs a free queue slot; every other byte is always taken.
    assign at_end      = collecting_reg && (pos_reg == POS_W'(STATUS_POS));
    assign rx_in.ready = !at_end || q_ready;
    assign accept      = rx_in.valid && rx_in.ready;
    assign pos_inc     = pos_reg + POS_W'(1);

    // Channel-count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_all_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            decode_all_reg <= cfg_wdata;
        end
    end

    // Frame collection.
    always_comb
    begin
        collecting_next = collecting_reg;
        pos_next        = pos_reg;
        payload_next    = payload_reg;
        status_next     = status_reg;
        q_push          = 1'b0;
        if (accept)
        begin
            if (rx_in.action == ACT_IDLE)
            begin
                collecting_next = 1'b0;
                pos_next        = '0;
            end
            else if (!collecting_reg)
            begin
                if (rx_in.rx_byte == START_BYTE)
                begin
                    collecting_next = 1'b1;
                    pos_next        = '0;
                end
            end
            else
            begin
                pos_next = pos_inc;
                if (pos_inc <= POS_W'(PAYLOAD_BYTES))
                begin
                    // Shift the payload down so byte 1 ends in the low bits.
                    payload_next = {rx_in.rx_byte, payload_reg[PAYLOAD_BITS-1:BYTE_W]};
                end
                else if (pos_inc == POS_W'(STATUS_POS))
                begin
                    status_next = rx_in.rx_byte;
                end
                else
                begin
                    q_push          = 1'b1;
                    collecting_next = 1'b0;
                    pos_next        = '0;
                end
            end
        end
    end

    // Descriptor of the completed frame.
    always_comb
    begin
        q_data.payload = payload_reg;
        q_data.error   = (rx_in.rx_byte != END_BYTE)
                      || ((status_reg & ~STATUS_FLAG_MASK) != '0);
        if (status_reg[FAILSAFE_BIT])
        begin
            q_data.status = STAT_FAILSAFE;
        end
        else if (status_reg[LOST_BIT])
        begin
            q_data.status = STAT_LOST;
        end
        else
        begin
            q_data.status = STAT_OK;
        end
        q_data.last_idx = decode_all_reg ? IDX_W'(CH_COUNT - 1)
                                         : IDX_W'(CHANNELS_MIN - 1);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collecting_reg <= 1'b0;
            pos_reg        <= '0;
        end
        else
        begin
            collecting_reg <= collecting_next;
            pos_reg        <= pos_next;
        end
    end

    // Frame bytes, no reset needed.
    always_ff @(posedge clk)
    begin
        payload_reg <= payload_next;
        status_reg  <= status_next;
    end

`ifndef SYNTHESIS
    a_hunt_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !collecting_reg |-> pos_reg == '0)
        else $error("byte position not cleared while hunting");
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(STATUS_POS))
        else $error("byte position beyond status byte");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> q_ready)
        else $error("descriptor pushed into full queue");
`endif

endmodule

`default_nettype wire

// File: rtl/sbfr_queue.sv
// Short descriptor queue between the front and back ends of the SBUS
// frame receiver. Depends on sbfr_pkg.
`default_nettype none

module sbfr_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire sbfr_pkg::sbfr_frame_t push_data,
    output      logic                  push_ready,
    input  wire logic                  pop,
    output      sbfr_pkg::sbfr_frame_t head,
    output      logic                  head_valid
);
    import sbfr_pkg::*;

    sbfr_frame_t       entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign push_ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    // Pointer and fill-count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage, written at the tail.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/sbfr_back.sv
// SBUS receiver back end: unpacks one channel per cycle, unless stalled, from
// the queued frame into the result register. Depends on sbfr_pkg, sbfr_out_if.
`default_nettype none

module sbfr_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sbfr_pkg::sbfr_frame_t head,
    input  wire logic                  head_valid,
    output      logic                  pop,
    sbfr_out_if.source                 res_out
);
    import sbfr_pkg::*;

    logic [IDX_W-1:0]  ch_reg, ch_next;
    logic              ov_reg, ov_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [CH_W-1:0]   value_reg;
    logic [STAT_W-1:0] status_reg;
    logic              error_reg;
    logic              last_reg;
    logic              load;
    logic              is_last;
    logic [OFF_W-1:0]  bit_off;
    logic [CH_W-1:0]   ch_value;

    // With a frame queued, a result loads if the output reg is free or drains.
    assign load     = head_valid && (!ov_reg || res_out.ready);
    assign is_last  = head.error || (ch_reg == head.last_idx);
    assign pop      = load && is_last;
    assign bit_off  = OFF_W'(CH_W * ch_reg);
    assign ch_value = head.payload[bit_off +: CH_W];

    // Channel counter and output valid.
    always_comb
    begin
        ch_next = ch_reg;
        ov_next = ov_reg;
        if (load)
        begin
            ov_next = 1'b1;
            ch_next = is_last ? '0 : ch_reg + IDX_W'(1);
        end
        else if (res_out.ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            ch_reg <= ch_next;
            ov_reg <= ov_next;
        end
    end

    // Result payload register; an error result carries zero fields.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            idx_reg    <= head.error ? '0 : ch_reg;
            value_reg  <= head.error ? '0 : ch_value;
            status_reg <= head.error ? STAT_OK : head.status;
            error_reg  <= head.error;
            last_reg   <= is_last;
        end
    end

    assign res_out.valid         = ov_reg;
    assign res_out.channel_index = idx_reg;
    assign res_out.channel_value = value_reg;
    assign res_out.signal_status = status_reg;
    assign res_out.frame_error   = error_reg;
    assign res_out.last          = last_reg;

`ifndef SYNTHESIS
    a_ch_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> ch_reg <= head.last_idx)
        else $error("channel counter beyond last channel of frame");
    a_ch_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> ch_reg == '0)
        else $error("channel counter not cleared with empty queue");
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_out.valid && res_out.frame_error) |-> res_out.last)
        else $error("error result not marked last");
`endif

endmodule

`default_nettype wire

// File: rtl/sbus_frame_receiver.sv
// SBUS frame receiver: one received byte or idle event per cycle in, decoded channels out.
// A frame enters the queue with its end byte; its results leave via the result register.
// Throughput: one byte per cycle in; the end byte of a frame waits only while both queue
// slots are full. The back end unpacks one channel per cycle unless the result output
// stalls, from a 2-deep frame queue: 8 or up to 16 results per good frame.
// Reset (rst_n, asynchronous, active low): hunting, empty queue, all channels enabled.
// Top level; depends on sbfr_pkg, sbfr_if, sbfr_front, sbfr_queue and sbfr_back.
`default_nettype none

module sbus_frame_receiver #(
    parameter int CHANNELS_PER_FRAME = sbfr_pkg::CHANNELS_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    sbfr_in_if.sink   rx_in,
    sbfr_out_if.source res_out,
    input  wire logic cfg_we,
    input  wire logic cfg_wdata
);
    import sbfr_pkg::*;

    logic        q_push;
    logic        q_ready;
    logic        q_pop;
    logic        q_valid;
    sbfr_frame_t q_data;
    sbfr_frame_t q_head;

    // Byte collection and frame checking.
    sbfr_front #(
        .CHANNELS_PER_FRAME (CHANNELS_PER_FRAME)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_in     (rx_in),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_push    (q_push),
        .q_data    (q_data),
        .q_ready   (q_ready)
    );

    // Completed frames waiting for the back end.
    sbfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_data),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head       (q_head),
        .head_valid (q_valid)
    );

    // Channel unpacking and result output.
    sbfr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .head_valid (q_valid),
        .pop        (q_pop),
        .res_out    (res_out)
    );

endmodule

`default_nettype wire

// File: tb/sbus_frame_receiver_test.sv
// Self-checking testbench for the SBUS frame receiver: feeds byte and idle
// transactions, predicts the decoded channels and checks every result.
// Depends on sbfr_pkg, the sbfr_in_if/sbfr_out_if interfaces and the RTL.
`timescale 1ns / 100ps

module sbus_frame_receiver_test;
    import sbfr_pkg::*;

    localparam int CHANNELS        = CHANNELS_DEFAULT;
    localparam int RESET_CYCLES    = 12;
    localparam int SETTLE_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int MAX_REPORTS     = 10;
    localparam int ITEMS_PER_PHASE = 18;
    localparam int NUM_PHASES      = 4;
    localparam logic [4:0] NO_ABORT = 5'd31;

    // How a row of the frame table is checked.
    typedef enum logic [1:0] {
        CHECK_PREDICTED,
        CHECK_CHANNELS,
        CHECK_ERROR
    } row_check_t;

    // One decoded result transaction.
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [CH_W-1:0]   value;
        logic [STAT_W-1:0] status;
        logic              err;
        logic              last;
    } chan_result_t;

    // One frame of stimulus: optional lead-in, start byte, body, and check.
    typedef struct packed {
        logic              write_cfg;   // set the channel mode before the frame
        logic              cfg_value;
        logic              lead_idle;   // idle transaction while hunting
        logic [1:0]        noise;       // stray bytes while hunting
        logic              rand_fill;   // random payload instead of fill
        logic [BYTE_W-1:0] fill;
        logic [4:0]        abort_at;    // idle after this many body bytes
        logic [BYTE_W-1:0] status_b;
        logic [BYTE_W-1:0] end_b;
        row_check_t        check;
        logic [CH_W-1:0]   exp_value;   // typed value of every channel
        logic [STAT_W-1:0] exp_status;
    } frame_row_t;

    // Directed frames: extremes, status priority, aborts, bad frames, modes.
    localparam frame_row_t DIRECTED_ROWS [17] = '{
        '{1'b0, 1'b0, 1'b1, 2'd2, 1'b0, 8'h00, NO_ABORT, 8'h00, 8'h00,
          CHECK_CHANNELS, 11'd0, STAT_OK},
        '{1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 8'hFF, NO_ABORT, 8'h08, 8'h00,
          CHECK_CHANNELS, 11'h7FF, STAT_FAILSAFE},
        '{1'b0, 1'b0, 1'b0, 2'd1, 1'b0, 8'hFF, NO_ABORT, 8'h0C, 8'h00,
          CHECK_CHANNELS, 11'h7FF, STAT_FAILSAFE},
        '{1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 8'h00, NO_ABORT, 8'h04, 8'h00,
          CHECK_CHANNELS, 11'd0, STAT_LOST},
        '{1'b0, 1'b0, 1'b0, 2'd0, 1'b1, 8'h00, 5'd10, 8'h00, 8'h00,
          CHECK_PREDICTED, 11'd0, STAT_OK},
        '{1'b0, 1'b0, 1'b0, 2'd0, 1'b1, 8'h00, 5'd0, 8'h00, 8'h00,
          CHECK_PREDICTED, 11'd0, STAT_OK},
        '{1'b0, 1'b0, 1'b0, 2'd0, 1'b0, START_BYTE, NO_ABORT, 8'h00, 8'h00,
          CHECK_PREDICTED, 11'd0, STAT_OK},
        '{1'b0, 1'b0, 1'b0, 2'd0, 1'b1, 8'h00, NO_ABORT, 8'h00, 8'hFF,
          CHECK_ERROR, 11'd0, STAT_OK},
        '{1'b0, 1'b0, 1'b0, 2'd0, 1'b1, 8'h00, NO_ABORT, 8'h01, 8'h00,
          CHECK_ERROR, 11'd0, STAT_OK},
        '{1'b0, 1'b0, 1'b0, 2'd0, 1'b1, 8'h00, NO_ABORT, 8'hFF, 8'h00,
          CHECK_ERROR, 11'd0, STAT_OK},
        '{1'b0, 1'b0, 1'b0, 2'd0, 1'b1, 8'h00, NO_ABORT, 8'h10, 8'h00,
          CHECK_ERROR, 11'd0, STAT_OK},
        '{1'b0, 1'b0, 1'b0, 2'd0, 1'b1, 8'h00, 5'd23, 8'h00, 8'h00,
          CHECK_PREDICTED, 11'd0, STAT_OK},
        '{1'b0, 1'b0, 1'b0, 2'd0, 1'b1, 8'h00, NO_ABORT, 8'h0C, 8'h00,
          CHECK_PREDICTED, 11'd0, STAT_OK},
        '{1'b1, 1'b0, 1'b0, 2'd0, 1'b0, 8'hFF, NO_ABORT, 8'h00, 8'h00,
          CHECK_CHANNELS, 11'h7FF, STAT_OK},
        '{1'b0, 1'b0, 1'b0, 2'd0, 1'b1, 8'h00, NO_ABORT, 8'h04, 8'h00,
          CHECK_PREDICTED, 11'd0, STAT_OK},
        '{1'b0, 1'b0, 1'b0, 2'd0, 1'b1, 8'h00, NO_ABORT, 8'h00, 8'h01,
          CHECK_ERROR, 11'd0, STAT_OK},
        '{1'b1, 1'b1, 1'b0, 2'd0, 1'b1, 8'h00, NO_ABORT, 8'h08, 8'h00,
          CHECK_PREDICTED, 11'd0, STAT_OK}
    };

    // Idling and channel mode of each random phase.
    localparam int   GAP_PCT   [NUM_PHASES] = '{0, 49, 0, 35};
    localparam int   STALL_PCT [NUM_PHASES] = '{0, 0, 49, 35};
    localparam logic PHASE_MODE [NUM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1};

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    sbfr_in_if  rx_if ();
    sbfr_out_if res_if ();

    // Decoder model state.
    logic              in_frame;
    logic [POS_W-1:0]  frame_pos;
    logic [BYTE_W-1:0] frame_buf [0:END_POS];
    logic              full_mode;

    chan_result_t expected_channels [$];

    int send_gap_pct;
    int sink_stall_pct;
    int mismatches;
    int results_checked;
    int frame_items;
    int frames_good;
    int frames_rejected;
    int frames_aborted;
    int quiet_cycles;

    chan_result_t seen_result;
    chan_result_t want_result;

    sbus_frame_receiver #(
        .CHANNELS_PER_FRAME(CHANNELS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_in    (rx_if),
        .res_out  (res_if),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Decode one accepted transaction and queue the channels it releases.
    task automatic decode_byte(input logic act, input logic [BYTE_W-1:0] b,
                               input bit keep);
        chan_result_t            r;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [BYTE_W-1:0]       st;
        int                      n;
        if (act == ACT_IDLE)
        begin
            if (in_frame)
                frames_aborted++;
            in_frame  = 1'b0;
            frame_pos = '0;
        end
        else if (!in_frame)
        begin
            if (b == START_BYTE)
            begin
                frame_buf[0] = b;
                frame_pos    = '0;
                in_frame     = 1'b1;
            end
        end
        else
        begin
            frame_pos            = frame_pos + 1'b1;
            frame_buf[frame_pos] = b;
            if (frame_pos == END_POS)
            begin
                in_frame  = 1'b0;
                frame_pos = '0;
                st        = frame_buf[STATUS_POS];
                if (frame_buf[END_POS] != END_BYTE || (st & ~STATUS_FLAG_MASK) != '0)
                begin
                    frames_rejected++;
                    r = '{idx: '0, value: '0, status: STAT_OK, err: 1'b1, last: 1'b1};
                    if (keep)
                        expected_channels.push_back(r);
                end
                else
                begin
                    frames_good++;
                    // Bytes 1..22 form one bit string, byte 1 at the bottom.
                    for (int i = 0; i < PAYLOAD_BYTES; i++)
                        payload[i*BYTE_W +: BYTE_W] = frame_buf[i+1];
                    n = full_mode ? CHANNELS : CHANNELS_MIN;
                    for (int k = 0; k < n; k++)
                    begin
                        r.idx    = IDX_W'(k);
                        r.value  = payload[k*CH_W +: CH_W];
                        r.status = st[FAILSAFE_BIT] ? STAT_FAILSAFE :
                                   st[LOST_BIT] ? STAT_LOST : STAT_OK;
                        r.err    = 1'b0;
                        r.last   = (k == n - 1);
                        if (keep)
                            expected_channels.push_back(r);
                    end
                end
            end
        end
    endtask

    // Offer one input transaction and hold it until it is accepted.
    task automatic put_item(input logic act, input logic [BYTE_W-1:0] b,
                            input bit keep);
        while ($urandom_range(99) < send_gap_pct)
        begin
            rx_if.valid   = 1'b0;
            rx_if.action  = 1'($urandom);
            rx_if.rx_byte = 8'($urandom);
            @(negedge clk);
        end
        rx_if.valid   = 1'b1;
        rx_if.action  = act;
        rx_if.rx_byte = b;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        decode_byte(act, b, keep);
        @(negedge clk);
    endtask

    // Let every queued result drain and the pipeline settle.
    task automatic wait_idle();
        rx_if.valid = 1'b0;
        while (expected_channels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write the channel mode register while the block is idle.
    task automatic set_channel_mode(input logic mode);
        wait_idle();
        cfg_wdata = mode;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
        full_mode = mode;
    endtask

    // Send one frame as described by a row, with its lead-in and check.
    task automatic send_frame(input frame_row_t row);
        logic [BYTE_W-1:0] b;
        chan_result_t      r;
        bit                keep;
        int                n;
        keep = (row.check == CHECK_PREDICTED);
        if (row.write_cfg)
            set_channel_mode(row.cfg_value);
        if (row.lead_idle)
            put_item(ACT_IDLE, 8'($urandom), keep);
        for (int i = 0; i < row.noise; i++)
        begin
            b = 8'($urandom);
            if (b == START_BYTE)
                b = ~b;
            put_item(ACT_BYTE, b, keep);
        end
        put_item(ACT_BYTE, START_BYTE, keep);
        frame_items++;
        for (int p = 1; p <= END_POS; p++)
        begin
            frame_items++;
            if (row.abort_at != NO_ABORT && p > row.abort_at)
            begin
                put_item(ACT_IDLE, 8'($urandom), keep);
                break;
            end
            if (p == STATUS_POS)
                b = row.status_b;
            else if (p == END_POS)
                b = row.end_b;
            else
                b = row.rand_fill ? 8'($urandom) : row.fill;
            put_item(ACT_BYTE, b, keep);
        end
        // Rows whose outcome is obvious carry it typed in.
        if (row.check == CHECK_ERROR)
        begin
            r = '{idx: '0, value: '0, status: STAT_OK, err: 1'b1, last: 1'b1};
            expected_channels.push_back(r);
        end
        else if (row.check == CHECK_CHANNELS)
        begin
            n = full_mode ? CHANNELS : CHANNELS_MIN;
            for (int k = 0; k < n; k++)
            begin
                r = '{idx: IDX_W'(k), value: row.exp_value, status: row.exp_status,
                      err: 1'b0, last: (k == n - 1)};
                expected_channels.push_back(r);
            end
        end
    endtask

    // Mostly well-formed frames with random content, some broken ones.
    function automatic frame_row_t random_row();
        frame_row_t r;
        int         kind;
        int         pick;
        r           = '0;
        kind        = $urandom_range(99);
        r.check     = CHECK_PREDICTED;
        r.abort_at  = NO_ABORT;
        r.lead_idle = ($urandom_range(7) == 0);
        r.noise     = 2'($urandom_range(3));
        r.rand_fill = ($urandom_range(9) != 0);
        case ($urandom_range(2))
            0: r.fill = 8'h00;
            1: r.fill = 8'hFF;
            default: r.fill = START_BYTE;
        endcase
        r.status_b = {4'h0, 2'($urandom_range(3)), 2'b00};
        r.end_b    = END_BYTE;
        if (kind >= 90)
            r.end_b = 8'($urandom_range(255, 1));
        else if (kind >= 80)
        begin
            // Any bit other than the two flags makes the status bad.
            pick = $urandom_range(5);
            if (pick >= LOST_BIT)
                pick += 2;
            r.status_b = 8'($urandom) | (8'h01 << pick);
        end
        else if (kind >= 70)
            r.abort_at = 5'($urandom_range(END_POS - 1));
        return r;
    endfunction

    task automatic report_result(input string what, input chan_result_t want,
                                 input chan_result_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t %s: expected idx=%0d value=%0d status=%0d err=%0b last=%0b,",
                     $realtime, what, want.idx, want.value, want.status, want.err,
                     want.last,
                     " got idx=%0d value=%0d status=%0d err=%0b last=%0b",
                     got.idx, got.value, got.status, got.err, got.last);
    endtask

    // Result receiver: random stalls as set by the current phase.
    always @(negedge clk)
    begin
        res_if.ready = ($urandom_range(99) >= sink_stall_pct);
    end

    // Compare every result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            seen_result = '{idx: res_if.channel_index, value: res_if.channel_value,
                            status: res_if.signal_status, err: res_if.frame_error,
                            last: res_if.last};
            results_checked++;
            if (expected_channels.size() == 0)
                report_result("unexpected result", '0, seen_result);
            else
            begin
                want_result = expected_channels.pop_front();
                if (seen_result.idx != want_result.idx
                    || seen_result.value != want_result.value
                    || seen_result.status != want_result.status
                    || seen_result.err != want_result.err
                    || seen_result.last != want_result.last)
                    report_result("result mismatch", want_result, seen_result);
            end
        end
    end

    // Watchdog: too long without any transaction on either side ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired with %0d results outstanding",
                         expected_channels.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Main sequence: reset, directed frames, random phases, final drain.
    initial
    begin
        int start_items;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = 1'b0;
        rx_if.valid     = 1'b0;
        rx_if.action    = ACT_BYTE;
        rx_if.rx_byte   = '0;
        res_if.ready    = 1'b0;
        send_gap_pct    = 0;
        sink_stall_pct  = 0;
        mismatches      = 0;
        results_checked = 0;
        frame_items     = 0;
        frames_good     = 0;
        frames_rejected = 0;
        frames_aborted  = 0;
        quiet_cycles    = 0;
        in_frame        = 1'b0;
        frame_pos       = '0;
        full_mode       = 1'b1;
        for (int i = 0; i <= END_POS; i++)
            frame_buf[i] = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (DIRECTED_ROWS[i])
            send_frame(DIRECTED_ROWS[i]);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_channel_mode(PHASE_MODE[p]);
            send_gap_pct   = GAP_PCT[p];
            sink_stall_pct = STALL_PCT[p];
            start_items    = frame_items;
            while (frame_items - start_items < ITEMS_PER_PHASE)
                send_frame(random_row());
        end

        wait_idle();
        if (expected_channels.size() != 0)
            mismatches++;

        $display("Sent %0d frame byte transactions: %0d good frames, %0d rejected, %0d aborted.",
                 frame_items, frames_good, frames_rejected, frames_aborted);
        $display("Checked %0d result transactions in both channel modes, %0d mismatches.",
                 results_checked, mismatches);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
rtl/sbfr_pkg.sv
rtl/sbfr_if.sv
rtl/sbfr_front.sv
rtl/sbfr_queue.sv
rtl/sbfr_back.sv
rtl/sbus_frame_receiver.sv
tb/sbus_frame_receiver_test.sv
